>>> hdl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

    localparam int PAGE_W  = 15;  // page number field
    localparam int CNT_W   = 16;  // free / total page counters
    localparam int CFG_W   = 10;  // words-in-use register
    localparam int IDX_W   = 12;  // word index of a page (words hold at least 8 pages)

    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [CFG_W-1:0] CFG_WIU_RST  = 10'd512;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_USABLE   = 2'd2,
        CMD_RESERVE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OOM       = 2'd1,
        ST_NOCHANGE  = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

endpackage

>>> hdl/bitmap_page_allocator_top.sv
// Bitmap page allocator: first-fit page frame allocator over a used/free bitmap in RAM.
//
// Input channel (i_valid/o_ready) takes one command beat: i_cmd selects alloc, free,
// mark_usable or reserve, i_page names the page (ignored by alloc). Each command yields
// exactly one result beat on the output channel (o_valid/i_ready) carrying status, the
// page, and the free and total page counts after the command.
// The configuration channel (i_cfg_valid/o_cfg_ready) writes the number of bitmap words
// in use; write it only while no command is outstanding.
// Commands are handled one at a time. free, mark_usable and reserve pass through the index
// split, one RAM read (the bit offset settles beside it), one read-modify-write and the load
// of the output register; a page out of range skips the read and the write.
// alloc reads one bitmap word per cycle through the single RAM read port up to the first
// word with a clear bit, then sets that bit and loads the output register; when no word
// in use has a clear bit it reports OOM. The next command can be taken as soon as the
// result is loaded.
// After reset the bitmap RAM is swept to all-ones, one word per cycle; o_ready stays low
// during the sweep, configuration is taken as usual.
// Both counts reset to zero. A result waits in the output register while i_ready is
// low; the block accepts the next command meanwhile but cannot finish it until the
// register is taken.
module bitmap_page_allocator_top #(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [bpa_pkg::PAGE_W-1:0]      i_page,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_status,
    output logic [bpa_pkg::PAGE_W-1:0]      o_page_out,
    output logic [bpa_pkg::CNT_W-1:0]       o_free_count,
    output logic [bpa_pkg::CNT_W-1:0]       o_total_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpa_pkg::CFG_W-1:0]       i_cfg_words_in_use
);

    localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int NW_W  = $clog2(NUM_WORDS + 1);
    localparam int CNTW  = (NW_W > bpa_pkg::CFG_W) ? NW_W : bpa_pkg::CFG_W;
    localparam int CMPW  = (CNTW > bpa_pkg::IDX_W) ? CNTW : bpa_pkg::IDX_W;
    localparam int OFFW  = $clog2(WORD_BITS);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SPLIT = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_MOD   = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_AFIND = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_clr, n_clr;
    logic [bpa_pkg::CFG_W-1:0]     r_wiu, n_wiu;
    logic [bpa_pkg::CNT_W-1:0]     r_free, n_free;
    logic [bpa_pkg::CNT_W-1:0]     r_total, n_total;
    logic                          r_ovalid, n_ovalid;
    bpa_pkg::t_cmd                 r_cmd, n_cmd;
    logic [bpa_pkg::PAGE_W-1:0]    r_page, n_page;
    logic [AW-1:0]                 r_scan, n_scan;
    logic [WORD_BITS-1:0]          r_word, n_word;
    bpa_pkg::t_status              r_res_status, n_res_status;
    logic [bpa_pkg::PAGE_W-1:0]    r_res_page, n_res_page;
    bpa_pkg::t_status              r_ostatus, n_ostatus;
    logic [bpa_pkg::PAGE_W-1:0]    r_opage, n_opage;
    logic [bpa_pkg::CNT_W-1:0]     r_ofree, n_ofree;
    logic [bpa_pkg::CNT_W-1:0]     r_ototal, n_ototal;

    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]          ram_wdata, ram_rdata;

    logic [bpa_pkg::IDX_W-1:0]     w_idx;
    logic [OFFW-1:0]               w_off;
    logic [CMPW-1:0]               w_idx_ext;
    logic [CNTW-1:0]               w_wiu_ext;
    logic [CNTW-1:0]               w_active;
    logic [OFFW-1:0]               w_ffz;
    logic [WORD_BITS-1:0]          w_ffz_bit;
    logic [WORD_BITS-1:0]          w_off_bit;
    logic                          w_used;
    logic [31:0]                   w_alloc_page;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpa_split #(
        .WORD_BITS (WORD_BITS)
    ) u_split (
        .i_clk  (i_clk),
        .i_page (r_page),
        .o_idx  (w_idx),
        .o_off  (w_off)
    );

    // clamp words in use to the bitmap depth
    assign w_wiu_ext = CNTW'(r_wiu);
    assign w_active  = (w_wiu_ext > CNTW'(NUM_WORDS)) ? CNTW'(NUM_WORDS) : w_wiu_ext;
    assign w_idx_ext = CMPW'(w_idx);

    // lowest clear bit of the held word
    always_comb begin
        w_ffz = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!r_word[b]) begin
                w_ffz = OFFW'(b);
            end
        end
    end

    assign w_ffz_bit    = {{(WORD_BITS-1){1'b0}}, 1'b1} << w_ffz;
    assign w_off_bit    = {{(WORD_BITS-1){1'b0}}, 1'b1} << w_off;
    assign w_used       = |(ram_rdata & w_off_bit);
    assign w_alloc_page = 32'(r_scan) * 32'(WORD_BITS) + 32'(w_ffz);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_wiu        = r_wiu;
        n_free       = r_free;
        n_total      = r_total;
        n_ovalid     = r_ovalid;
        n_cmd        = r_cmd;
        n_page       = r_page;
        n_scan       = r_scan;
        n_word       = r_word;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_ostatus    = r_ostatus;
        n_opage      = r_opage;
        n_ofree      = r_ofree;
        n_ototal     = r_ototal;
        ram_we       = 1'b0;
        ram_waddr    = r_scan;
        ram_wdata    = '1;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        if (i_cfg_valid) begin
            n_wiu = i_cfg_words_in_use;
        end
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '1;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = bpa_pkg::t_cmd'(i_cmd);
                    n_page = i_page;
                    if (bpa_pkg::t_cmd'(i_cmd) == bpa_pkg::CMD_ALLOC) begin
                        if (w_active == '0) begin
                            n_res_status = bpa_pkg::ST_OOM;
                            n_res_page   = '0;
                            n_state      = S_OUT;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_scan    = '0;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_idx_ext >= CMPW'(w_active)) begin
                    n_res_status = bpa_pkg::ST_RANGE;
                    n_res_page   = r_page;
                    n_state      = S_OUT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = w_idx_ext[AW-1:0];
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                n_res_page   = r_page;
                n_res_status = bpa_pkg::ST_DONE;
                ram_waddr    = w_idx_ext[AW-1:0];
                case (r_cmd)
                    bpa_pkg::CMD_FREE: begin
                        if (w_used) begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~w_off_bit;
                            n_free    = (r_free == bpa_pkg::CNT_MAX) ? r_free : r_free + 1'b1;
                        end else begin
                            n_res_status = bpa_pkg::ST_NOCHANGE;
                        end
                    end
                    bpa_pkg::CMD_USABLE: begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~w_off_bit;
                        n_free    = (r_free == bpa_pkg::CNT_MAX) ? r_free : r_free + 1'b1;
                        n_total   = (r_total == bpa_pkg::CNT_MAX) ? r_total : r_total + 1'b1;
                    end
                    bpa_pkg::CMD_RESERVE: begin
                        if (!w_used) begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | w_off_bit;
                            n_free    = (r_free == '0) ? r_free : r_free - 1'b1;
                        end else begin
                            n_res_status = bpa_pkg::ST_NOCHANGE;
                        end
                    end
                    default: begin
                        n_res_status = bpa_pkg::ST_DONE;
                    end
                endcase
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (ram_rdata != '1) begin
                    n_word  = ram_rdata;
                    n_state = S_AFIND;
                end else if (CNTW'(r_scan) + CNTW'(1) == w_active) begin
                    n_res_status = bpa_pkg::ST_OOM;
                    n_res_page   = '0;
                    n_state      = S_OUT;
                end else begin
                    // advance to the next word
                    n_scan    = r_scan + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = r_scan + 1'b1;
                end
            end
            S_AFIND: begin
                ram_we       = 1'b1;
                ram_waddr    = r_scan;
                ram_wdata    = r_word | w_ffz_bit;
                n_free       = (r_free == '0) ? r_free : r_free - 1'b1;
                n_res_status = bpa_pkg::ST_DONE;
                n_res_page   = w_alloc_page[bpa_pkg::PAGE_W-1:0];
                n_state      = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    n_opage   = r_res_page;
                    n_ofree   = r_free;
                    n_ototal  = r_total;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wiu    <= bpa_pkg::CFG_WIU_RST;
            r_free   <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_wiu    <= n_wiu;
            r_free   <= n_free;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_page       <= n_page;
        r_scan       <= n_scan;
        r_word       <= n_word;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_ostatus    <= n_ostatus;
        r_opage      <= n_opage;
        r_ofree      <= n_ofree;
        r_ototal     <= n_ototal;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_page_out    = r_opage;
    assign o_free_count  = r_ofree;
    assign o_total_count = r_ototal;

endmodule

>>> hdl/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> hdl/bpa_split.sv
// Page number to word index and bit offset, by reciprocal multiply over two stages.
module bpa_split #(
    parameter int WORD_BITS = 64
) (
    input  logic                               i_clk,
    input  logic [bpa_pkg::PAGE_W-1:0]         i_page,
    output logic [bpa_pkg::IDX_W-1:0]          o_idx,
    output logic [$clog2(WORD_BITS)-1:0]       o_off
);

    localparam int SHIFT = 22;
    localparam int RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECW  = 20;
    localparam int PRODW = bpa_pkg::PAGE_W + RECW;
    localparam int OFFW  = $clog2(WORD_BITS);

    logic [PRODW-1:0]          w_prod;
    logic [31:0]               w_rem;
    logic [bpa_pkg::IDX_W-1:0] r_idx;
    logic [OFFW-1:0]           r_off;

    // floor(page / WORD_BITS) is exact for every 15-bit page with this shift
    assign w_prod = PRODW'(i_page) * PRODW'(RECIP);
    assign w_rem  = 32'(i_page) - 32'(r_idx) * 32'(WORD_BITS);

    always_ff @(posedge i_clk) begin
        r_idx <= w_prod[SHIFT +: bpa_pkg::IDX_W];
        r_off <= w_rem[OFFW-1:0];
    end

    assign o_idx = r_idx;
    assign o_off = r_off;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the bitmap page allocator: directed table, then random phases.
`timescale 1ns / 100ps

module tb;

    localparam int WORD_BITS   = 64;
    localparam int NUM_WORDS   = 512;
    localparam int RST_CYCLES  = 11;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int N_DIR = 26;
    localparam int N_PH  = 7;

    typedef struct packed {
        bpa_pkg::t_status                   status;
        logic [bpa_pkg::PAGE_W-1:0]         page;
        logic [bpa_pkg::CNT_W-1:0]          free_cnt;
        logic [bpa_pkg::CNT_W-1:0]          total_cnt;
    } t_alloc_result;

    typedef struct packed {
        bit                                 is_cfg;
        bpa_pkg::t_cmd                      cmd;
        logic [bpa_pkg::PAGE_W-1:0]         arg;    // page, or the words-in-use value
        bit                                 lit;    // expectation typed in below
        t_alloc_result                      want;
    } t_dir_row;

    localparam t_alloc_result NO_WANT = '{bpa_pkg::ST_DONE, '0, '0, '0};

    // Walk from an empty map through every command and the range and count corners.
    t_dir_row dir_rows [N_DIR] = '{
        '{1'b1, bpa_pkg::CMD_ALLOC, 15'd0, 1'b0, NO_WANT},
        '{1'b0, bpa_pkg::CMD_ALLOC, 15'd0, 1'b1,
          '{bpa_pkg::ST_OOM, 15'd0, 16'd0, 16'd0}},
        '{1'b0, bpa_pkg::CMD_FREE, 15'd0, 1'b1,
          '{bpa_pkg::ST_RANGE, 15'd0, 16'd0, 16'd0}},
        '{1'b0, bpa_pkg::CMD_USABLE, 15'd32767, 1'b1,
          '{bpa_pkg::ST_RANGE, 15'd32767, 16'd0, 16'd0}},
        '{1'b0, bpa_pkg::CMD_RESERVE, 15'd10922, 1'b1,
          '{bpa_pkg::ST_RANGE, 15'd10922, 16'd0, 16'd0}},
        '{1'b1, bpa_pkg::CMD_ALLOC, 15'd1023, 1'b0, NO_WANT},
        '{1'b0, bpa_pkg::CMD_USABLE, 15'd32767, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd32767, 16'd1, 16'd1}},
        '{1'b0, bpa_pkg::CMD_RESERVE, 15'd32767, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd32767, 16'd0, 16'd1}},
        '{1'b0, bpa_pkg::CMD_RESERVE, 15'd32767, 1'b1,
          '{bpa_pkg::ST_NOCHANGE, 15'd32767, 16'd0, 16'd1}},
        '{1'b0, bpa_pkg::CMD_FREE, 15'd32767, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd32767, 16'd1, 16'd1}},
        '{1'b0, bpa_pkg::CMD_FREE, 15'd32767, 1'b1,
          '{bpa_pkg::ST_NOCHANGE, 15'd32767, 16'd1, 16'd1}},
        '{1'b0, bpa_pkg::CMD_USABLE, 15'd32767, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd32767, 16'd2, 16'd2}},
        '{1'b1, bpa_pkg::CMD_ALLOC, 15'd1, 1'b0, NO_WANT},
        '{1'b0, bpa_pkg::CMD_ALLOC, 15'd0, 1'b1,
          '{bpa_pkg::ST_OOM, 15'd0, 16'd2, 16'd2}},
        '{1'b0, bpa_pkg::CMD_USABLE, 15'd0, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd0, 16'd3, 16'd3}},
        '{1'b0, bpa_pkg::CMD_USABLE, 15'd63, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd63, 16'd4, 16'd4}},
        '{1'b0, bpa_pkg::CMD_FREE, 15'd64, 1'b1,
          '{bpa_pkg::ST_RANGE, 15'd64, 16'd4, 16'd4}},
        '{1'b0, bpa_pkg::CMD_ALLOC, 15'd0, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd0, 16'd3, 16'd4}},
        '{1'b0, bpa_pkg::CMD_ALLOC, 15'd21845, 1'b1,
          '{bpa_pkg::ST_DONE, 15'd63, 16'd2, 16'd4}},
        '{1'b0, bpa_pkg::CMD_ALLOC, 15'd0, 1'b1,
          '{bpa_pkg::ST_OOM, 15'd0, 16'd2, 16'd4}},
        '{1'b0, bpa_pkg::CMD_RESERVE, 15'd5, 1'b1,
          '{bpa_pkg::ST_NOCHANGE, 15'd5, 16'd2, 16'd4}},
        '{1'b1, bpa_pkg::CMD_ALLOC, 15'd512, 1'b0, NO_WANT},
        '{1'b0, bpa_pkg::CMD_USABLE, 15'd21845, 1'b0, NO_WANT},
        '{1'b0, bpa_pkg::CMD_ALLOC, 15'd0, 1'b0, NO_WANT},
        '{1'b0, bpa_pkg::CMD_FREE, 15'd10922, 1'b0, NO_WANT},
        '{1'b0, bpa_pkg::CMD_ALLOC, 15'd0, 1'b0, NO_WANT}
    };

    // Random phases: words in use, sender idle %, receiver stall %, commands, long hold.
    localparam int PH_WIU   [N_PH] = '{4, 1, 512, 37, 1023, 0, 2};
    localparam int PH_SND   [N_PH] = '{0, 45, 0, 25, 0, 0, 25};
    localparam int PH_RCV   [N_PH] = '{0, 0, 45, 25, 0, 0, 25};
    localparam int PH_ITEMS [N_PH] = '{260, 240, 260, 260, 240, 40, 225};
    localparam bit PH_HOLD  [N_PH] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic [1:0]                       i_cmd = '0;
    logic [bpa_pkg::PAGE_W-1:0]       i_page = '0;
    logic                             i_ready = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic [bpa_pkg::CFG_W-1:0]        i_cfg_words_in_use = '0;
    logic                             o_ready;
    logic                             o_valid;
    logic [1:0]                       o_status;
    logic [bpa_pkg::PAGE_W-1:0]       o_page_out;
    logic [bpa_pkg::CNT_W-1:0]        o_free_count;
    logic [bpa_pkg::CNT_W-1:0]        o_total_count;
    logic                             o_cfg_ready;

    // Mirror of the allocator state.
    logic [WORD_BITS-1:0]             page_map [NUM_WORDS];
    logic [bpa_pkg::CNT_W-1:0]        mir_free = '0;
    logic [bpa_pkg::CNT_W-1:0]        mir_total = '0;
    logic [bpa_pkg::CFG_W-1:0]        wiu_reg = bpa_pkg::CFG_WIU_RST;

    t_alloc_result page_replies [$];
    int            mismatches = 0;
    int            snd_idle_pct = 0;
    int            rcv_stall_pct = 0;
    bit            hold_req = 1'b0;
    int unsigned   cycle_count = 0;

    bitmap_page_allocator_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_page             (i_page),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_page_out         (o_page_out),
        .o_free_count       (o_free_count),
        .o_total_count      (o_total_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_words_in_use (i_cfg_words_in_use)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Apply one command to the mirrored map and return the result it must produce.
    function automatic t_alloc_result apply_page_cmd(bpa_pkg::t_cmd cmd,
                                                     logic [bpa_pkg::PAGE_W-1:0] page);
        t_alloc_result r;
        int            span;
        int            w;
        int            b;
        int            idx;
        int            off;
        bit            found;
        span = (int'(wiu_reg) > NUM_WORDS) ? NUM_WORDS : int'(wiu_reg);
        idx = int'(page) / WORD_BITS;
        off = int'(page) % WORD_BITS;
        found = 1'b0;
        r.status = bpa_pkg::ST_DONE;
        r.page = page;
        if (cmd == bpa_pkg::CMD_ALLOC) begin
            r.page = '0;
            for (w = 0; w < span && !found; w++) begin
                if (page_map[w] != '1) begin
                    for (b = 0; b < WORD_BITS && !found; b++) begin
                        if (!page_map[w][b]) begin
                            page_map[w][b] = 1'b1;
                            if (mir_free != '0) mir_free--;
                            r.page = bpa_pkg::PAGE_W'(w * WORD_BITS + b);
                            found = 1'b1;
                        end
                    end
                end
            end
            if (!found) r.status = bpa_pkg::ST_OOM;
        end else if (idx >= span) begin
            r.status = bpa_pkg::ST_RANGE;
        end else begin
            case (cmd)
                bpa_pkg::CMD_FREE: begin
                    if (page_map[idx][off]) begin
                        page_map[idx][off] = 1'b0;
                        if (mir_free != bpa_pkg::CNT_MAX) mir_free++;
                    end else begin
                        r.status = bpa_pkg::ST_NOCHANGE;
                    end
                end
                bpa_pkg::CMD_USABLE: begin
                    page_map[idx][off] = 1'b0;
                    if (mir_free != bpa_pkg::CNT_MAX) mir_free++;
                    if (mir_total != bpa_pkg::CNT_MAX) mir_total++;
                end
                default: begin
                    if (!page_map[idx][off]) begin
                        page_map[idx][off] = 1'b1;
                        if (mir_free != '0) mir_free--;
                    end else begin
                        r.status = bpa_pkg::ST_NOCHANGE;
                    end
                end
            endcase
        end
        r.free_cnt = mir_free;
        r.total_cnt = mir_total;
        return r;
    endfunction

    // Mostly pages in the low words so allocs stay short; some anywhere in the field.
    function automatic logic [bpa_pkg::PAGE_W-1:0] pick_page();
        int hot;
        hot = (int'(wiu_reg) > 8) ? 8 : int'(wiu_reg);
        if (hot == 0 || $urandom_range(0, 99) < 15)
            return bpa_pkg::PAGE_W'($urandom_range(0, 32767));
        return bpa_pkg::PAGE_W'($urandom_range(0, hot * WORD_BITS - 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_page_cmd(input bpa_pkg::t_cmd c,
                                 input logic [bpa_pkg::PAGE_W-1:0] p, input bit lit,
                                 input t_alloc_result want, output t_alloc_result pred);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= c;
        i_page  <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = apply_page_cmd(c, p);
        page_replies.push_back(lit ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain_replies();
        i_valid <= 1'b0;
        while (page_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_wiu(input logic [bpa_pkg::CFG_W-1:0] v);
        i_cfg_valid        <= 1'b1;
        i_cfg_words_in_use <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        wiu_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : rx_drive
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (page_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: status %0d page %0d free %0d total %0d",
                             o_status, o_page_out, o_free_count, o_total_count);
            end else begin
                exp_r = page_replies.pop_front();
                if (o_status !== exp_r.status || o_page_out !== exp_r.page ||
                    o_free_count !== exp_r.free_cnt || o_total_count !== exp_r.total_cnt) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch at cycle %0d: expected status %0d page %0d ",
                                  "free %0d total %0d, got status %0d page %0d free %0d ",
                                  "total %0d"}, cycle_count,
                                 exp_r.status, exp_r.page, exp_r.free_cnt, exp_r.total_cnt,
                                 o_status, o_page_out, o_free_count, o_total_count);
                end
            end
        end
    end

    initial begin : main_seq
        int                         k;
        int                         ph;
        int                         n;
        int                         sel;
        int                         oi;
        bpa_pkg::t_cmd              c;
        logic [bpa_pkg::PAGE_W-1:0] p;
        t_alloc_result              pred;
        logic [bpa_pkg::PAGE_W-1:0] owned [$];

        for (k = 0; k < NUM_WORDS; k++) page_map[k] = '1;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].is_cfg) begin
                drain_replies();
                write_wiu(bpa_pkg::CFG_W'(dir_rows[k].arg));
            end else begin
                send_page_cmd(dir_rows[k].cmd, dir_rows[k].arg, dir_rows[k].lit,
                              dir_rows[k].want, pred);
            end
        end

        for (ph = 0; ph < N_PH; ph++) begin
            drain_replies();
            write_wiu(bpa_pkg::CFG_W'(PH_WIU[ph]));
            snd_idle_pct  = PH_SND[ph];
            rcv_stall_pct = PH_RCV[ph];
            if (PH_HOLD[ph]) hold_req = 1'b1;
            for (n = 0; n < PH_ITEMS[ph]; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 30) begin
                    c = bpa_pkg::CMD_ALLOC;
                    p = bpa_pkg::PAGE_W'($urandom_range(0, 32767));
                end else if (sel < 55 && owned.size() != 0) begin
                    // hand back a page taken earlier
                    c = bpa_pkg::CMD_FREE;
                    oi = $urandom_range(0, owned.size() - 1);
                    p = owned[oi];
                    owned.delete(oi);
                end else if (sel < 75) begin
                    c = bpa_pkg::CMD_USABLE;
                    p = pick_page();
                end else if (sel < 85) begin
                    c = bpa_pkg::CMD_RESERVE;
                    p = pick_page();
                end else begin
                    c = bpa_pkg::t_cmd'($urandom_range(0, 3));
                    p = bpa_pkg::PAGE_W'($urandom_range(0, 32767));
                end
                send_page_cmd(c, p, 1'b0, NO_WANT, pred);
                if (pred.status == bpa_pkg::ST_DONE &&
                    (c == bpa_pkg::CMD_ALLOC || c == bpa_pkg::CMD_RESERVE))
                    owned.push_back((c == bpa_pkg::CMD_ALLOC) ? pred.page : p);
            end
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
